// File: rtl/sgr_escape_encoder_defines.svh
// Assertion helpers shared by the encoder. Every property is sampled on the
// rising edge of clk_i and is switched off while rst_ni is low.
`ifndef SGR_ESCAPE_ENCODER_DEFINES_SVH
`define SGR_ESCAPE_ENCODER_DEFINES_SVH

// Same-cycle implication.
`define SGR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SGR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sgr_pkg.sv
package sgr_pkg;

  // Field widths of a pen and of one output byte.
  localparam int unsigned KindW  = 2;
  localparam int unsigned ValueW = 24;
  localparam int unsigned FlagW  = 7;
  localparam int unsigned ByteW  = 8;

  // ASCII codes used in the sequence.
  localparam logic [7:0] ChrEsc  = 8'h1B;
  localparam logic [7:0] ChrLbr  = 8'h5B;
  localparam logic [7:0] ChrSemi = 8'h3B;
  localparam logic [7:0] ChrZero = 8'h30;
  localparam logic [7:0] ChrM    = 8'h6D;

  // Colour kinds; the unused code is decoded as the terminal default.
  typedef enum logic [1:0] {
    KIND_DEFAULT = 2'd0,
    KIND_PALETTE = 2'd1,
    KIND_RGB     = 2'd2
  } kind_e;

  // Which byte the datapath drives onto the output register.
  typedef enum logic [3:0] {
    BYTE_ESC,
    BYTE_LBR,
    BYTE_ZERO,
    BYTE_SEMI,
    BYTE_FLAG,
    BYTE_LAYER,
    BYTE_KIND,
    BYTE_FORM,
    BYTE_HUND,
    BYTE_TENS,
    BYTE_ONES,
    BYTE_M
  } byte_sel_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD_ESC,
    ST_HEAD_LBR,
    ST_HEAD_ZERO,
    ST_FLAG_SEMI,
    ST_FLAG_DIG,
    ST_COL_SEMI,
    ST_COL_LAYER,
    ST_COL_KIND,
    ST_FORM_SEMI,
    ST_FORM_DIG,
    ST_NUM_SEMI,
    ST_NUM_HUND,
    ST_NUM_TENS,
    ST_NUM_ONES,
    ST_TAIL
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic      load;   // capture the pen on the input transfer
    logic      emit;   // load one byte into the output register
    byte_sel_e sel;    // which byte
    logic      layer;  // 0 foreground, 1 background
    logic [1:0] comp;  // colour byte: 0 red, 1 green, 2 blue or palette index
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic  out_free;    // output register can take a byte this cycle
    logic  flags_any;   // at least one attribute flag left to emit
    logic  flags_more;  // more than one attribute flag left
    kind_e kind;        // kind of the selected layer
    logic  has_hund;    // selected colour byte has a hundreds digit
    logic  has_tens;    // selected colour byte has a tens digit
  } stat_t;

  // SGR parameter digit for each attribute flag bit.
  function automatic logic [7:0] flag_code(input logic [2:0] idx);
    logic [7:0] code;
    unique case (idx)
      3'd0:    code = 8'h31;
      3'd1:    code = 8'h32;
      3'd2:    code = 8'h33;
      3'd3:    code = 8'h34;
      3'd4:    code = 8'h35;
      3'd5:    code = 8'h37;
      3'd6:    code = 8'h39;
      default: code = 8'h30;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/sgr_if.sv
// Pen channel: one pen per transfer.
interface sgr_pen_if;
  logic                            valid;
  logic                            ready;
  logic [sgr_pkg::KindW-1:0]  fg_kind;
  logic [sgr_pkg::ValueW-1:0] fg_value;
  logic [sgr_pkg::KindW-1:0]  bg_kind;
  logic [sgr_pkg::ValueW-1:0] bg_value;
  logic [sgr_pkg::FlagW-1:0]  attr_flags;

  modport source (output valid, fg_kind, fg_value, bg_kind, bg_value, attr_flags,
                  input ready);
  modport sink (input valid, fg_kind, fg_value, bg_kind, bg_value, attr_flags,
                output ready);
endinterface

// Byte channel: one character of the escape sequence per transfer.
interface sgr_byte_if;
  logic                           valid;
  logic                           ready;
  logic [sgr_pkg::ByteW-1:0] out_byte;
  logic                           last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

// File: rtl/sgr_ctrl.sv
module sgr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pen_valid_i,
  output logic             pen_ready_o,
  input  sgr_pkg::stat_t   stat_i,
  output sgr_pkg::cmd_t    cmd_o
);

  sgr_pkg::state_e state_q, state_d;
  logic            layer_q, layer_d;
  logic [1:0]      comp_q, comp_d;

  // State and position registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sgr_pkg::ST_IDLE;
      layer_q <= 1'b0;
      comp_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      layer_q <= layer_d;
      comp_q  <= comp_d;
    end
  end

  // Next state and commands. Every state but idle emits one byte and moves
  // on only when the output register takes it.
  always_comb begin
    state_d     = state_q;
    layer_d     = layer_q;
    comp_d      = comp_q;
    pen_ready_o = 1'b0;
    cmd_o.load  = 1'b0;
    cmd_o.emit  = (state_q != sgr_pkg::ST_IDLE) && stat_i.out_free;
    cmd_o.sel   = sgr_pkg::BYTE_ESC;
    cmd_o.layer = layer_q;
    cmd_o.comp  = comp_q;

    unique case (state_q)
      sgr_pkg::ST_IDLE: begin
        pen_ready_o = 1'b1;
        if (pen_valid_i) begin
          cmd_o.load = 1'b1;
          layer_d    = 1'b0;
          state_d    = sgr_pkg::ST_HEAD_ESC;
        end
      end
      sgr_pkg::ST_HEAD_ESC: begin
        cmd_o.sel = sgr_pkg::BYTE_ESC;
        if (stat_i.out_free) state_d = sgr_pkg::ST_HEAD_LBR;
      end
      sgr_pkg::ST_HEAD_LBR: begin
        cmd_o.sel = sgr_pkg::BYTE_LBR;
        if (stat_i.out_free) state_d = sgr_pkg::ST_HEAD_ZERO;
      end
      sgr_pkg::ST_HEAD_ZERO: begin
        cmd_o.sel = sgr_pkg::BYTE_ZERO;
        if (stat_i.out_free) begin
          state_d = stat_i.flags_any ? sgr_pkg::ST_FLAG_SEMI : sgr_pkg::ST_COL_SEMI;
        end
      end
      sgr_pkg::ST_FLAG_SEMI: begin
        cmd_o.sel = sgr_pkg::BYTE_SEMI;
        if (stat_i.out_free) state_d = sgr_pkg::ST_FLAG_DIG;
      end
      sgr_pkg::ST_FLAG_DIG: begin
        cmd_o.sel = sgr_pkg::BYTE_FLAG;
        if (stat_i.out_free) begin
          state_d = stat_i.flags_more ? sgr_pkg::ST_FLAG_SEMI : sgr_pkg::ST_COL_SEMI;
        end
      end
      sgr_pkg::ST_COL_SEMI: begin
        cmd_o.sel = sgr_pkg::BYTE_SEMI;
        if (stat_i.out_free) state_d = sgr_pkg::ST_COL_LAYER;
      end
      sgr_pkg::ST_COL_LAYER: begin
        cmd_o.sel = sgr_pkg::BYTE_LAYER;
        if (stat_i.out_free) state_d = sgr_pkg::ST_COL_KIND;
      end
      sgr_pkg::ST_COL_KIND: begin
        cmd_o.sel = sgr_pkg::BYTE_KIND;
        if (stat_i.out_free) begin
          if (stat_i.kind != sgr_pkg::KIND_DEFAULT) begin
            state_d = sgr_pkg::ST_FORM_SEMI;
          end else if (!layer_q) begin
            layer_d = 1'b1;
            state_d = sgr_pkg::ST_COL_SEMI;
          end else begin
            state_d = sgr_pkg::ST_TAIL;
          end
        end
      end
      sgr_pkg::ST_FORM_SEMI: begin
        cmd_o.sel = sgr_pkg::BYTE_SEMI;
        if (stat_i.out_free) state_d = sgr_pkg::ST_FORM_DIG;
      end
      sgr_pkg::ST_FORM_DIG: begin
        cmd_o.sel = sgr_pkg::BYTE_FORM;
        if (stat_i.out_free) begin
          // RGB walks red, green, blue; a palette index sits in the blue byte.
          comp_d  = (stat_i.kind == sgr_pkg::KIND_RGB) ? 2'd0 : 2'd2;
          state_d = sgr_pkg::ST_NUM_SEMI;
        end
      end
      sgr_pkg::ST_NUM_SEMI: begin
        cmd_o.sel = sgr_pkg::BYTE_SEMI;
        if (stat_i.out_free) begin
          if (stat_i.has_hund)      state_d = sgr_pkg::ST_NUM_HUND;
          else if (stat_i.has_tens) state_d = sgr_pkg::ST_NUM_TENS;
          else                      state_d = sgr_pkg::ST_NUM_ONES;
        end
      end
      sgr_pkg::ST_NUM_HUND: begin
        cmd_o.sel = sgr_pkg::BYTE_HUND;
        if (stat_i.out_free) state_d = sgr_pkg::ST_NUM_TENS;
      end
      sgr_pkg::ST_NUM_TENS: begin
        cmd_o.sel = sgr_pkg::BYTE_TENS;
        if (stat_i.out_free) state_d = sgr_pkg::ST_NUM_ONES;
      end
      sgr_pkg::ST_NUM_ONES: begin
        cmd_o.sel = sgr_pkg::BYTE_ONES;
        if (stat_i.out_free) begin
          if (comp_q != 2'd2) begin
            comp_d  = comp_q + 2'd1;
            state_d = sgr_pkg::ST_NUM_SEMI;
          end else if (!layer_q) begin
            layer_d = 1'b1;
            state_d = sgr_pkg::ST_COL_SEMI;
          end else begin
            state_d = sgr_pkg::ST_TAIL;
          end
        end
      end
      sgr_pkg::ST_TAIL: begin
        cmd_o.sel = sgr_pkg::BYTE_M;
        if (stat_i.out_free) state_d = sgr_pkg::ST_IDLE;
      end
      default: begin
        state_d = sgr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/sgr_dp.sv
module sgr_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [sgr_pkg::KindW-1:0]  fg_kind_i,
  input  logic [sgr_pkg::ValueW-1:0] fg_value_i,
  input  logic [sgr_pkg::KindW-1:0]  bg_kind_i,
  input  logic [sgr_pkg::ValueW-1:0] bg_value_i,
  input  logic [sgr_pkg::FlagW-1:0]  attr_flags_i,
  input  sgr_pkg::cmd_t              cmd_i,
  output sgr_pkg::stat_t             stat_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [sgr_pkg::ByteW-1:0]  out_byte_o,
  output logic                       out_last_o
);

  logic [sgr_pkg::KindW-1:0]  fg_kind_q, bg_kind_q;
  logic [sgr_pkg::ValueW-1:0] fg_value_q, bg_value_q;
  logic [sgr_pkg::FlagW-1:0]  flags_q, flags_d;
  logic                       out_valid_q;
  logic [sgr_pkg::ByteW-1:0]  out_byte_q, out_byte_d;
  logic                       out_last_q;

  logic [sgr_pkg::KindW-1:0]  cur_kind;
  logic [sgr_pkg::ValueW-1:0] cur_value;
  sgr_pkg::kind_e             kind;
  logic [7:0]                 comp_v;
  logic [1:0]                 hund;
  logic [6:0]                 rem;
  logic [14:0]                prod;
  logic [3:0]                 tens, ones;
  logic [2:0]                 flag_idx;
  logic                       out_free;

  // Pen registers; the flag word drains one flag per emitted flag digit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      fg_kind_q  <= fg_kind_i;
      fg_value_q <= fg_value_i;
      bg_kind_q  <= bg_kind_i;
      bg_value_q <= bg_value_i;
    end
    flags_q <= flags_d;
  end

  always_comb begin
    flags_d = flags_q;
    if (cmd_i.load) begin
      flags_d = attr_flags_i;
    end else if (cmd_i.emit && (cmd_i.sel == sgr_pkg::BYTE_FLAG)) begin
      flags_d = flags_q & (flags_q - sgr_pkg::FlagW'(1));
    end
  end

  // Lowest flag still pending.
  always_comb begin
    flag_idx = 3'd0;
    for (int i = sgr_pkg::FlagW - 1; i >= 0; i--) begin
      if (flags_q[i]) flag_idx = 3'(i);
    end
  end

  // Selected layer and its colour byte.
  assign cur_kind  = cmd_i.layer ? bg_kind_q : fg_kind_q;
  assign cur_value = cmd_i.layer ? bg_value_q : fg_value_q;

  always_comb begin
    case (cur_kind)
      2'd1:    kind = sgr_pkg::KIND_PALETTE;
      2'd2:    kind = sgr_pkg::KIND_RGB;
      default: kind = sgr_pkg::KIND_DEFAULT;
    endcase
  end

  always_comb begin
    case (cmd_i.comp)
      2'd0:    comp_v = cur_value[23:16];
      2'd1:    comp_v = cur_value[15:8];
      default: comp_v = cur_value[7:0];
    endcase
  end

  // Decimal digits of the colour byte; tens by multiplying with 205/2048.
  always_comb begin
    if (comp_v >= 8'd200)      hund = 2'd2;
    else if (comp_v >= 8'd100) hund = 2'd1;
    else                       hund = 2'd0;
    rem  = 7'(comp_v - 8'(8'(hund) * 8'd100));
    prod = 15'(rem) * 15'd205;
    tens = prod[14:11];
    ones = 4'(rem - 7'(7'(tens) * 7'd10));
  end

  // Byte selection.
  always_comb begin
    unique case (cmd_i.sel)
      sgr_pkg::BYTE_ESC:   out_byte_d = sgr_pkg::ChrEsc;
      sgr_pkg::BYTE_LBR:   out_byte_d = sgr_pkg::ChrLbr;
      sgr_pkg::BYTE_ZERO:  out_byte_d = sgr_pkg::ChrZero;
      sgr_pkg::BYTE_SEMI:  out_byte_d = sgr_pkg::ChrSemi;
      sgr_pkg::BYTE_FLAG:  out_byte_d = sgr_pkg::flag_code(flag_idx);
      sgr_pkg::BYTE_LAYER: out_byte_d = cmd_i.layer ? 8'h34 : 8'h33;
      sgr_pkg::BYTE_KIND:  out_byte_d = (kind == sgr_pkg::KIND_DEFAULT) ? 8'h39 : 8'h38;
      sgr_pkg::BYTE_FORM:  out_byte_d = (kind == sgr_pkg::KIND_RGB) ? 8'h32 : 8'h35;
      sgr_pkg::BYTE_HUND:  out_byte_d = sgr_pkg::ChrZero + 8'(hund);
      sgr_pkg::BYTE_TENS:  out_byte_d = sgr_pkg::ChrZero + 8'(tens);
      sgr_pkg::BYTE_ONES:  out_byte_d = sgr_pkg::ChrZero + 8'(ones);
      sgr_pkg::BYTE_M:     out_byte_d = sgr_pkg::ChrM;
      default:             out_byte_d = sgr_pkg::ChrZero;
    endcase
  end

  // Output register: takes a new byte whenever it is empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q <= out_byte_d;
      out_last_q <= (cmd_i.sel == sgr_pkg::BYTE_M);
    end
  end

  // Status back to the controller.
  assign stat_o.out_free   = out_free;
  assign stat_o.flags_any  = |flags_q;
  assign stat_o.flags_more = |(flags_q & (flags_q - sgr_pkg::FlagW'(1)));
  assign stat_o.kind       = kind;
  assign stat_o.has_hund   = (comp_v >= 8'd100);
  assign stat_o.has_tens   = (comp_v >= 8'd10);

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

// File: rtl/sgr_escape_encoder.sv
// SGR escape sequence encoder. Each pen taken on pen_i (foreground and
// background colour, each default, palette or RGB, plus seven attribute flags)
// comes out on seq_o as the ANSI sequence ESC [ 0 ;flags ;fg ;bg m, one ASCII
// byte per transfer, with last_byte set on the closing 'm'. A pen yields 10 to
// 52 bytes; the byte sequencer emits one byte per cycle while the sink takes
// them. A pen is taken only in the idle state, ahead of its first byte, and
// the next pen is taken once the closing byte has entered the output
// register. A kind code of 3 is treated as the terminal default, and a
// palette colour uses only the low 8 bits of its value.
`include "sgr_escape_encoder_defines.svh"

module sgr_escape_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  sgr_pen_if.sink     pen_i,
  sgr_byte_if.source  seq_o
);

  sgr_pkg::cmd_t  cmd;
  sgr_pkg::stat_t stat;
  logic           pen_ready;

  // Sequencer.
  sgr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pen_valid_i (pen_i.valid),
    .pen_ready_o (pen_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Pen storage, digit logic and output register.
  sgr_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fg_kind_i    (pen_i.fg_kind),
    .fg_value_i   (pen_i.fg_value),
    .bg_kind_i    (pen_i.bg_kind),
    .bg_value_i   (pen_i.bg_value),
    .attr_flags_i (pen_i.attr_flags),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (seq_o.ready),
    .out_valid_o  (seq_o.valid),
    .out_byte_o   (seq_o.out_byte),
    .out_last_o   (seq_o.last_byte)
  );

  assign pen_i.ready = pen_ready;

  // A byte is only loaded when the output register has room.
  `SGR_ASSERT_IMP(a_emit_room, cmd.emit, !seq_o.valid || seq_o.ready,
                  "byte loaded into a full output register")
  // Every sequence starts with ESC right after the pen transfer.
  `SGR_ASSERT_NXT(a_start_esc, pen_i.valid && pen_i.ready, cmd.sel == sgr_pkg::BYTE_ESC,
                  "sequence does not start with ESC")
  // After the closing byte the encoder is free for the next pen.
  `SGR_ASSERT_NXT(a_tail_idle, cmd.emit && (cmd.sel == sgr_pkg::BYTE_M), pen_i.ready,
                  "encoder not idle after the closing byte")
  // A flag digit is only emitted while a flag is pending.
  `SGR_ASSERT_IMP(a_flag_pending, cmd.emit && (cmd.sel == sgr_pkg::BYTE_FLAG),
                  stat.flags_any, "flag digit emitted with no flag pending")

endmodule

// File: dv/sgr_seq_checker.sv
// Watches the pen and byte channels of the SGR encoder, predicts the escape
// sequence for every pen taken and compares each byte that leaves the block
// against it, in order.
module sgr_seq_checker
  import sgr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  sgr_pen_if         pen_i,
  sgr_byte_if        seq_i,
  output int         mismatch_cnt_o,
  output int         pending_o,
  output int         bytes_checked_o
);

  // One predicted character of a sequence and its end marker.
  typedef struct packed {
    logic [ByteW-1:0] chr;
    logic             last;
  } seq_chr_t;

  // Characters still owed by the block, oldest first.
  seq_chr_t         seq_exp_q[$];
  // Scratch buffer for the pen being encoded.
  logic [ByteW-1:0] pen_chars[$];
  int               mismatch_cnt  = 0;
  int               bytes_checked = 0;

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      pen_chars.push_back(s[i]);
    end
  endfunction

  // Decimal digits of one color byte, without leading zeros.
  function automatic void put_number(input logic [7:0] v);
    if (v >= 8'd100) begin
      pen_chars.push_back(ChrZero + v / 8'd100);
    end
    if (v >= 8'd10) begin
      pen_chars.push_back(ChrZero + (v / 8'd10) % 8'd10);
    end
    pen_chars.push_back(ChrZero + v % 8'd10);
  endfunction

  // One color field; the unused kind code falls into the default form.
  function automatic void put_color(input logic [KindW-1:0] kind,
                                    input logic [ValueW-1:0] value,
                                    input logic is_bg);
    string lead;
    lead = is_bg ? ";4" : ";3";
    case (kind)
      KIND_RGB: begin
        put_text({lead, "8;2;"});
        put_number(value[23:16]);
        pen_chars.push_back(ChrSemi);
        put_number(value[15:8]);
        pen_chars.push_back(ChrSemi);
        put_number(value[7:0]);
      end
      KIND_PALETTE: begin
        put_text({lead, "8;5;"});
        put_number(value[7:0]);
      end
      default: begin
        put_text({lead, "9"});
      end
    endcase
  endfunction

  // Builds the full sequence for one pen and queues it, marking the 'm'.
  function automatic void encode_pen(input logic [KindW-1:0] fg_kind,
                                     input logic [ValueW-1:0] fg_value,
                                     input logic [KindW-1:0] bg_kind,
                                     input logic [ValueW-1:0] bg_value,
                                     input logic [FlagW-1:0] flags);
    string flag_digits;
    flag_digits = "1234579";
    pen_chars.delete();
    pen_chars.push_back(ChrEsc);
    pen_chars.push_back(ChrLbr);
    pen_chars.push_back(ChrZero);
    for (int i = 0; i < FlagW; i++) begin
      if (flags[i]) begin
        pen_chars.push_back(ChrSemi);
        pen_chars.push_back(flag_digits[i]);
      end
    end
    put_color(fg_kind, fg_value, 1'b0);
    put_color(bg_kind, bg_value, 1'b1);
    pen_chars.push_back(ChrM);
    foreach (pen_chars[i]) begin
      seq_exp_q.push_back(seq_chr_t'{chr: pen_chars[i],
                                     last: (i == pen_chars.size() - 1)});
    end
  endfunction

  // Compare the outgoing byte first, then record the pen taken at this edge.
  always @(posedge clk_i) begin
    seq_chr_t want;
    if (rst_ni) begin
      if (seq_i.valid && seq_i.ready) begin
        if (seq_exp_q.size() == 0) begin
          $display("%0t: byte 0x%02h last=%0b with no sequence pending",
                   $time, seq_i.out_byte, seq_i.last_byte);
          mismatch_cnt++;
        end else begin
          want = seq_exp_q.pop_front();
          bytes_checked++;
          if (seq_i.out_byte !== want.chr) begin
            $display("%0t: out_byte expected 0x%02h, got 0x%02h",
                     $time, want.chr, seq_i.out_byte);
            mismatch_cnt++;
          end
          if (seq_i.last_byte !== want.last) begin
            $display("%0t: last_byte expected %0b, got %0b",
                     $time, want.last, seq_i.last_byte);
            mismatch_cnt++;
          end
        end
      end
      if (pen_i.valid && pen_i.ready) begin
        encode_pen(pen_i.fg_kind, pen_i.fg_value, pen_i.bg_kind, pen_i.bg_value,
                   pen_i.attr_flags);
      end
    end
    mismatch_cnt_o  <= mismatch_cnt;
    pending_o       <= seq_exp_q.size();
    bytes_checked_o <= bytes_checked;
  end

endmodule

// File: dv/tb.sv
// Drives pens into the SGR encoder with bursty timing and a changing stall
// pattern on the byte side; the checker beside the block does the comparing.
module tb;
  import sgr_pkg::*;

  // Kind code with no meaning of its own; the block treats it as default.
  localparam logic [KindW-1:0] KindUnused = 2'd3;
  localparam int               PenCount   = 420;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   mismatch_cnt;
  int   pending;
  int   bytes_checked;
  int   pens_sent = 0;
  int   pens_directed;

  sgr_pen_if  pen ();
  sgr_byte_if seq ();

  sgr_escape_encoder DUT (
    .clk_i,
    .rst_ni,
    .pen_i (pen),
    .seq_o (seq)
  );

  sgr_seq_checker u_seq_check (
    .clk_i,
    .rst_ni,
    .pen_i           (pen),
    .seq_i           (seq),
    .mismatch_cnt_o  (mismatch_cnt),
    .pending_o       (pending),
    .bytes_checked_o (bytes_checked)
  );

  always #2 clk_i = ~clk_i;

  // Give up if the run hangs.
  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver readiness: a new pattern is picked for every stretch of cycles.
  initial begin
    stall_e mode;
    int     span;
    mode      = STALL_NONE;
    span      = 0;
    seq.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (span == 0) begin
        mode = stall_e'($urandom_range(0, 3));
        span = $urandom_range(20, 120);
      end
      span--;
      case (mode)
        STALL_NONE:   seq.ready <= 1'b1;
        STALL_RANDOM: seq.ready <= ($urandom_range(0, 1) == 1);
        STALL_HEAVY:  seq.ready <= ($urandom_range(0, 7) == 0);
        default:      seq.ready <= ((span % 6) < 4);
      endcase
    end
  end

  // Offers one pen and holds it until the transfer happens.
  task automatic send_pen(input logic [KindW-1:0] fg_kind,
                          input logic [ValueW-1:0] fg_value,
                          input logic [KindW-1:0] bg_kind,
                          input logic [ValueW-1:0] bg_value,
                          input logic [FlagW-1:0] flags);
    pen.valid      <= 1'b1;
    pen.fg_kind    <= fg_kind;
    pen.fg_value   <= fg_value;
    pen.bg_kind    <= bg_kind;
    pen.bg_value   <= bg_value;
    pen.attr_flags <= flags;
    @(posedge clk_i);
    while (!pen.ready) @(posedge clk_i);
    pens_sent++;
  endtask

  // Drops valid for a number of cycles.
  task automatic pause_sender(input int cycles);
    pen.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Holds off until every predicted byte has come out.
  task automatic wait_drained();
    pen.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Color byte biased toward the one, two and three digit boundaries.
  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'($urandom_range(1, 9));
      2:       return 8'($urandom_range(10, 99));
      3:       return 8'($urandom_range(100, 254));
      4:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [ValueW-1:0] pick_color();
    if ($urandom_range(0, 1) == 1) begin
      return ValueW'($urandom);
    end
    return {pick_level(), pick_level(), pick_level()};
  endfunction

  function automatic logic [KindW-1:0] pick_kind();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) begin
      return KIND_DEFAULT;
    end else if (r < 6) begin
      return KIND_PALETTE;
    end else if (r < 9) begin
      return KIND_RGB;
    end
    return KindUnused;
  endfunction

  function automatic logic [FlagW-1:0] pick_flags();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return FlagW'($urandom);
    endcase
  endfunction

  // Stimulus: directed pens, then random bursts, then the verdict.
  initial begin
    int  burst;
    bit  drained_mid;
    drained_mid    = 1'b0;
    pen.valid      = 1'b0;
    pen.fg_kind    = '0;
    pen.fg_value   = '0;
    pen.bg_kind    = '0;
    pen.bg_value   = '0;
    pen.attr_flags = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Shortest and longest sequences.
    send_pen(KIND_DEFAULT, '0, KIND_DEFAULT, '0, '0);
    send_pen(KIND_RGB, 24'hFFFFFF, KIND_RGB, 24'hFFFFFF, '1);
    // Palette extremes, and palette values with junk in the upper bits.
    send_pen(KIND_PALETTE, 24'h000000, KIND_PALETTE, 24'h0000FF, '0);
    send_pen(KIND_PALETTE, 24'hABCD09, KIND_PALETTE, 24'hFFFF0A, 7'h55);
    send_pen(KIND_PALETTE, 24'hFFFF63, KIND_PALETTE, 24'h123464, 7'h2A);
    // Unused kind code and default color with a value that must be ignored.
    send_pen(KindUnused, 24'hFFFFFF, KindUnused, 24'h5A5A5A, '0);
    send_pen(KIND_DEFAULT, 24'hFFFFFF, KIND_DEFAULT, 24'hA5A5A5, 7'h01);
    // RGB components across digit-count boundaries.
    send_pen(KIND_RGB, 24'h00090A, KIND_RGB, 24'h6364FF, '0);
    send_pen(KIND_RGB, 24'h000000, KIND_DEFAULT, '0, '0);
    send_pen(KIND_DEFAULT, '0, KIND_RGB, 24'h640A09, 7'h40);
    send_pen(KIND_RGB, 24'hC80163, KindUnused, '0, '1);
    // Each attribute flag on its own.
    for (int i = 0; i < FlagW; i++) begin
      send_pen(KIND_DEFAULT, '0, KIND_DEFAULT, '0, FlagW'(1 << i));
    end
    pens_directed = pens_sent;
    wait_drained();

    // Random pens in bursts; some bursts run straight into the next one.
    while (pens_sent < pens_directed + PenCount) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        send_pen(pick_kind(), pick_color(), pick_kind(), pick_color(), pick_flags());
      end
      if (!drained_mid && pens_sent >= pens_directed + PenCount / 2) begin
        drained_mid = 1'b1;
        wait_drained();
      end else if ($urandom_range(0, 3) != 0) begin
        pause_sender($urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 6));
      end
    end

    wait_drained();
    repeat (60) @(posedge clk_i);

    $display("Sent %0d pens (%0d directed, the rest random) under bursty input",
             pens_sent, pens_directed);
    $display("and shifting output stalls; %0d sequence bytes were compared.",
             bytes_checked);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
